// File: src/whm_pkg.sv
`default_nettype none

package whm_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned LANES   = 4;
    localparam int unsigned STATE_N = 8;

    // Mixing constants, one per state word.
    localparam logic [WORD_W-1:0] MIXK [STATE_N] = '{
        64'h9e3779b185ebca87, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b03e58a,
        64'h1f12759bd39c024f, 64'h5be0cd19137e2179
    };

    localparam logic [WORD_W-1:0] FIN_C1   = 64'hff51afd7ed558ccd;
    localparam logic [WORD_W-1:0] FIN_C2   = 64'hc4ceb9fe1a85ec53;
    localparam logic [7:0]        PAD_MARK = 8'h80;

    // Request to one multiplier lane.
    typedef struct packed {
        logic              load;
        logic [WORD_W-1:0] operand;
        logic [WORD_W-1:0] factor;
    } lane_req_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input logic [5:0] n);
        return (v << n) | (v >> (7'd64 - {1'b0, n}));
    endfunction

    function automatic logic [WORD_W-1:0] avalanche_shift(input logic [WORD_W-1:0] v);
        return v ^ (v >> 33);
    endfunction

    // Pads word j of a tail block: bytes below the count are kept, the marker
    // follows, the rest is zero.
    function automatic logic [WORD_W-1:0] pad_word(input logic [WORD_W-1:0] w,
                                                   input logic [4:0] n,
                                                   input logic [1:0] j);
        logic [WORD_W-1:0] r;
        r = '0;
        if (n[4:3] > j) begin
            r = w;
        end
        else if (n[4:3] == j) begin
            for (int b = 0; b < 8; b++) begin
                if (3'(b) < n[2:0]) begin
                    r[b*8 +: 8] = w[b*8 +: 8];
                end
                else if (3'(b) == n[2:0]) begin
                    r[b*8 +: 8] = PAD_MARK;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/whm_in_if.sv
`default_nettype none

interface whm_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_word0;
    logic [63:0] block_word1;
    logic [63:0] block_word2;
    logic [63:0] block_word3;
    logic        start_of_message;
    logic        end_of_message;
    logic [31:0] message_length;

    modport source (
        output valid, block_word0, block_word1, block_word2, block_word3,
               start_of_message, end_of_message, message_length,
        input  ready
    );

    modport sink (
        input  valid, block_word0, block_word1, block_word2, block_word3,
               start_of_message, end_of_message, message_length,
        output ready
    );
endinterface

`default_nettype wire

// File: src/whm_out_if.sv
`default_nettype none

interface whm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;

    modport source (
        output valid, digest_word0, digest_word1, digest_word2, digest_word3,
        input  ready
    );

    modport sink (
        input  valid, digest_word0, digest_word1, digest_word2, digest_word3,
        output ready
    );
endinterface

`default_nettype wire

// File: src/whm_lane.sv
`default_nettype none

module whm_lane (
    input  wire logic                  clk,
    input  wire whm_pkg::lane_req_t    req,
    output logic [whm_pkg::WORD_W-1:0] product
);
    import whm_pkg::*;

    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] k_reg;
    logic [WORD_W-1:0] low_reg;
    logic [31:0]       cross_reg;

    // Low 64 bits of a 64 by 64 product, built from three 32-bit multiplies.
    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            a_reg <= req.operand;
            k_reg <= req.factor;
        end
        low_reg   <= 64'(a_reg[31:0]) * 64'(k_reg[31:0]);
        cross_reg <= a_reg[63:32] * k_reg[31:0] + a_reg[31:0] * k_reg[63:32];
    end

    assign product = low_reg + {cross_reg, 32'h0};

endmodule

`default_nettype wire

// File: src/wide_state_block_hash_256_top.sv
`default_nettype none

// Block hash with a 512-bit mixing state and a 256-bit digest.
// The blocks channel carries one 32-byte block per beat as four little-endian
// 64-bit words, with start and end flags; the message length is read on the
// start beat. The digests channel carries one 256-bit digest per end beat.
// The seed register is written through seed_wr_en / seed_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
// A block beat is taken only when the previous one has been fully mixed.
// A beat that does not end a message is taken, then the lane operands are
// formed, then it passes through the pipelined 64-bit multipliers of the four
// lanes (states PREP, MUL1, WB). An end beat adds a fold and two avalanche
// multiplies (FOLD, MULA, AV2, MULB) before its digest is registered in DONE.
// Beats of an empty message skip the mixing multiplies (MUL1 and WB).
// The multiplier lanes are two-stage.
// The digest waits in an output register; the next message may start while it
// waits, and only a further digest stalls until the receiver takes the beat.
// Reset clears the mixing state, the seed and the output valid flag.
module wide_state_block_hash_256_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    whm_in_if.sink     blocks,
    whm_out_if.source  digests,
    input  wire logic  seed_wr_en,
    input  wire logic [63:0] seed_wr_data
);
    import whm_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_MUL1 = 4'd2;
    localparam logic [3:0] ST_WB   = 4'd3;
    localparam logic [3:0] ST_FOLD = 4'd4;
    localparam logic [3:0] ST_MULA = 4'd5;
    localparam logic [3:0] ST_AV2  = 4'd6;
    localparam logic [3:0] ST_MULB = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] mix_reg [STATE_N];
    logic [4:0]        tail_reg;
    logic              empty_reg;
    logic              end_reg;
    logic [WORD_W-1:0] word_reg [LANES];
    logic [WORD_W-1:0] digest_reg [LANES];
    logic              out_valid_reg;

    lane_req_t         req [LANES];
    logic [WORD_W-1:0] prod [LANES];

    logic              accept;
    logic              tail_mode;
    logic              out_free;

    // Full round operands.
    logic [WORD_W-1:0] p [STATE_N];
    logic [WORD_W-1:0] round_hi [LANES];

    // Fold of the state into four avalanche inputs.
    logic [WORD_W-1:0] fa [LANES];
    logic [WORD_W-1:0] fb [LANES];
    logic [WORD_W-1:0] g [STATE_N];
    logic [WORD_W-1:0] fold_v [LANES];

    assign accept    = blocks.valid && blocks.ready;
    assign tail_mode = end_reg && (tail_reg != 5'd0);
    assign out_free  = !out_valid_reg || digests.ready;

    assign blocks.ready = (state_reg == ST_IDLE);

    // The lanes: each one works on one word of the block or of the digest.
    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        whm_lane u_lane (
            .clk     (clk),
            .req     (req[j]),
            .product (prod[j])
        );
    end

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            p[j]     = mix_reg[j] ^ word_reg[j];
            p[j + 4] = mix_reg[j + 4] + p[j];
        end
        round_hi[0] = rotl(p[4] + p[3], 6'd37) ^ MIXK[4];
        round_hi[1] = rotl(p[5] + p[4], 6'd41) ^ MIXK[5];
        round_hi[2] = rotl(p[6] + p[5], 6'd17) ^ MIXK[6];
        round_hi[3] = rotl(p[7] + p[6], 6'd29) ^ MIXK[7];

        for (int i = 0; i < LANES; i++)
        begin
            fa[i] = mix_reg[i] ^ rotl(mix_reg[i + 4], 6'd27);
        end
        fa[0] = fa[0] ^ rotl(fa[2], 6'd13);
        fa[1] = fa[1] ^ rotl(fa[3], 6'd13);
        fb[0] = mix_reg[4] ^ rotl(mix_reg[6], 6'd13);
        fb[1] = mix_reg[5] ^ rotl(mix_reg[7], 6'd13);
        fb[2] = mix_reg[6];
        fb[3] = mix_reg[7];
        g[0] = fa[0] + fa[1];
        g[1] = fa[1];
        g[2] = fa[2] + fa[3];
        g[3] = fa[3];
        g[4] = fb[0] + fb[1];
        g[5] = fb[1];
        g[6] = fb[2] + fb[3];
        g[7] = fb[3];
        for (int i = 0; i < LANES; i++)
        begin
            fold_v[i] = avalanche_shift(g[i] ^ g[i + 4]);
        end
    end

    // Lane requests for each phase of the sequence.
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            req[j].load    = 1'b0;
            req[j].operand = fold_v[j];
            req[j].factor  = FIN_C1;
        end
        case (state_reg)
            ST_PREP:
            begin
                for (int j = 0; j < LANES; j++)
                begin
                    req[j].load   = !empty_reg;
                    req[j].factor = MIXK[j];
                    if (tail_mode)
                    begin
                        req[j].operand = pad_word(word_reg[j], tail_reg, 2'(j));
                    end
                end
                if (!tail_mode)
                begin
                    req[0].operand = rotl(p[0] ^ p[7], 6'd23);
                    req[1].operand = rotl(p[1] ^ p[0], 6'd19);
                    req[2].operand = rotl(p[2] ^ p[1], 6'd31);
                    req[3].operand = rotl(p[3] ^ p[2], 6'd13);
                end
            end
            ST_FOLD:
            begin
                for (int j = 0; j < LANES; j++)
                begin
                    req[j].load = 1'b1;
                end
            end
            ST_AV2:
            begin
                for (int j = 0; j < LANES; j++)
                begin
                    req[j].load    = 1'b1;
                    req[j].operand = avalanche_shift(prod[j]);
                    req[j].factor  = FIN_C2;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_PREP;
            ST_PREP:
            begin
                if (!empty_reg)
                begin
                    state_next = ST_MUL1;
                end
                else
                begin
                    state_next = end_reg ? ST_FOLD : ST_IDLE;
                end
            end
            ST_MUL1: state_next = ST_WB;
            ST_WB:   state_next = end_reg ? ST_FOLD : ST_IDLE;
            ST_FOLD: state_next = ST_MULA;
            ST_MULA: state_next = ST_AV2;
            ST_AV2:  state_next = ST_MULB;
            ST_MULB: state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STATE_N; i++)
            begin
                mix_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (seed_wr_en)
            begin
                seed_reg <= seed_wr_data;
            end

            if (accept)
            begin
                end_reg <= blocks.end_of_message;
                if (blocks.start_of_message)
                begin
                    for (int j = 0; j < LANES; j++)
                    begin
                        mix_reg[j]     <= seed_reg ^ MIXK[j];
                        mix_reg[j + 4] <= {32'h0, blocks.message_length} ^ MIXK[j + 4];
                    end
                    tail_reg  <= blocks.message_length[4:0];
                    empty_reg <= (blocks.message_length == 32'h0);
                end
            end

            // The upper half of a full round is settled before the multiplies.
            if (state_reg == ST_PREP && !empty_reg && !tail_mode)
            begin
                for (int j = 0; j < LANES; j++)
                begin
                    mix_reg[j + 4] <= round_hi[j];
                end
            end

            if (state_reg == ST_WB)
            begin
                for (int j = 0; j < LANES; j++)
                begin
                    if (tail_mode)
                    begin
                        mix_reg[j]     <= mix_reg[j] ^ rotl(prod[j], 6'd15);
                        mix_reg[j + 4] <= mix_reg[j + 4] + rotl(prod[j], 6'd15);
                    end
                    else
                    begin
                        mix_reg[j] <= prod[j];
                    end
                end
            end

            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (digests.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg[0] <= blocks.block_word0;
            word_reg[1] <= blocks.block_word1;
            word_reg[2] <= blocks.block_word2;
            word_reg[3] <= blocks.block_word3;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                digest_reg[j] <= avalanche_shift(prod[j]);
            end
        end
    end

    assign digests.valid        = out_valid_reg;
    assign digests.digest_word0 = digest_reg[0];
    assign digests.digest_word1 = digest_reg[1];
    assign digests.digest_word2 = digest_reg[2];
    assign digests.digest_word3 = digest_reg[3];

endmodule

`default_nettype wire
